// ----- sv/ubh_pkg.sv -----
package ubh_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_MAX_CELLS  = 256;
  localparam int unsigned DEF_COUNT_BITS = 32;

  // Register and field widths
  localparam int unsigned NUM_CELLS_W = 9;
  localparam int unsigned MAX_VALUE_W = 31;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned PRODUCT_W   = MAX_VALUE_W + NUM_CELLS_W;

  // Reset values of the registers
  localparam logic [NUM_CELLS_W-1:0] NUM_CELLS_RST = NUM_CELLS_W'(256);
  localparam logic [MAX_VALUE_W-1:0] MAX_VALUE_RST = MAX_VALUE_W'(65536);

  // Register indexes
  localparam logic REG_NUM_CELLS = 1'b0;
  localparam logic REG_MAX_VALUE = 1'b1;

  // Operations
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [1:0] status_t;

  localparam status_t ST_COUNTED   = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;
  localparam status_t ST_READ      = 2'd3;

endpackage

// ----- sv/ubh_ram.sv -----
module ubh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/uniform_bin_histogram.sv -----
// An in-range add below max_value runs from accept to result word through one multiply,
// nine shift-subtract steps of the divider and a read-modify-write of the bin RAM.
// An add equal to max_value skips the divider; overflow and underflow adds go straight to the
// result word, and a read only reads the bin RAM. One word is in work at a time, so in_ready
// returns the cycle after the result word is loaded, and no new word is taken before that.
// Reset (rst, synchronous) clears the totals and loads the register defaults, then sweeps
// the bin RAM to zero with in_ready low; config writes are taken meanwhile.
module uniform_bin_histogram #(
  parameter int unsigned MAX_CELLS  = ubh_pkg::DEF_MAX_CELLS,
  parameter int unsigned COUNT_BITS = ubh_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [ubh_pkg::MAX_VALUE_W-1:0]     cfg_data,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic signed [ubh_pkg::SAMPLE_W-1:0] sample,
  input  logic [ubh_pkg::INDEX_W-1:0]         read_cell,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output ubh_pkg::status_t                    status,
  output logic [ubh_pkg::INDEX_W-1:0]         cell_index,
  output logic [ubh_pkg::TOTAL_W-1:0]         cell_count,
  output logic [ubh_pkg::TOTAL_W-1:0]         in_range_total,
  output logic [ubh_pkg::TOTAL_W-1:0]         overflow_total,
  output logic [ubh_pkg::TOTAL_W-1:0]         underflow_total
);

  localparam int unsigned AW       = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned NW       = ubh_pkg::NUM_CELLS_W;
  localparam int unsigned VW       = ubh_pkg::MAX_VALUE_W;
  localparam int unsigned PW       = ubh_pkg::PRODUCT_W;
  localparam int unsigned SW       = $clog2(NW);
  localparam int unsigned NUM_MAX  = (1 << NW) - 1;
  localparam int unsigned CELL_CAP = (MAX_CELLS > NUM_MAX) ? NUM_MAX : MAX_CELLS;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_RMW   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]            state;

  // configuration registers
  logic [NW-1:0]         num_cells;
  logic [VW-1:0]         max_value;
  logic [NW-1:0]         n_eff;
  logic [VW-1:0]         mv_eff;

  // captured input word
  logic                  op;
  logic [VW-1:0]         raw;
  logic                  rd_ok;

  // divider: remainder and quotient/dividend shift register
  logic [VW-1:0]         rem;
  logic [NW-1:0]         quo;
  logic [SW-1:0]         step;
  logic [VW:0]           trial;
  logic                  trial_ge;
  logic [PW-1:0]         product;

  // bin RAM access
  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         addr;
  logic [AW-1:0]         ram_addr;
  logic                  ram_we;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cell_inc;
  logic [NW-1:0]         pick;

  // totals
  logic [COUNT_BITS-1:0] in_range_count;
  logic [COUNT_BITS-1:0] overflow_count;
  logic [COUNT_BITS-1:0] underflow_count;

  // result held until the output register is free
  ubh_pkg::status_t        res_status;
  logic [ubh_pkg::INDEX_W-1:0] res_index;
  logic [COUNT_BITS-1:0]   res_count;

  // Clamp the cell count to 1..CELL_CAP (MAX_CELLS, at most 511) and the right edge to at least 1.
  always_comb begin
    if (num_cells == '0) begin
      n_eff = NW'(1);
    end else if (num_cells > NW'(CELL_CAP)) begin
      n_eff = NW'(CELL_CAP);
    end else begin
      n_eff = num_cells;
    end
    mv_eff = (max_value == '0) ? VW'(1) : max_value;
  end

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  // The remainder stays below max_value, so the trial fits in VW+1 bits.
  assign trial    = {rem, quo[NW-1]};
  assign trial_ge = (trial >= {1'b0, mv_eff});
  assign product  = PW'(raw) * PW'(n_eff);

  // Guard against a quotient that runs past the last cell.
  assign pick = (quo >= n_eff) ? (n_eff - NW'(1)) : quo;

  assign cell_inc  = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
  assign ram_addr  = (state == S_CLEAR) ? clr_addr : addr;
  assign ram_we    = (state == S_CLEAR) || ((state == S_RMW) && (op == ubh_pkg::OP_ADD));
  assign ram_wdata = (state == S_CLEAR) ? '0 : cell_inc;

  assign in_ready = (state == S_IDLE);

  ubh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_CELLS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Configuration writes land at any time; the user must keep them to idle periods (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cells <= ubh_pkg::NUM_CELLS_RST;
      max_value <= ubh_pkg::MAX_VALUE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ubh_pkg::REG_NUM_CELLS: num_cells <= cfg_data[NW-1:0];
        ubh_pkg::REG_MAX_VALUE: max_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      in_range_count  <= '0;
      overflow_count  <= '0;
      underflow_count <= '0;
      out_valid       <= 1'b0;
    end else begin
      // drop the output word once taken; the done state loads its own
      if (out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            raw   <= sample[VW-1:0];
            rd_ok <= (32'(read_cell) < 32'(MAX_CELLS));
            if (opcode == ubh_pkg::OP_READ) begin
              addr      <= AW'(read_cell);
              res_index <= read_cell;
              state     <= S_READ;
            end else if (sample[ubh_pkg::SAMPLE_W-1]) begin
              if (underflow_count != '1) begin
                underflow_count <= underflow_count + COUNT_BITS'(1);
              end
              res_status <= ubh_pkg::ST_UNDERFLOW;
              res_index  <= '0;
              res_count  <= '0;
              state      <= S_DONE;
            end else if (sample[VW-1:0] > mv_eff) begin
              if (overflow_count != '1) begin
                overflow_count <= overflow_count + COUNT_BITS'(1);
              end
              res_status <= ubh_pkg::ST_OVERFLOW;
              res_index  <= '0;
              res_count  <= '0;
              state      <= S_DONE;
            end else if (sample[VW-1:0] == mv_eff) begin
              // right edge belongs to the last cell
              quo   <= n_eff - NW'(1);
              state <= S_PICK;
            end else begin
              state <= S_MUL;
            end
          end
        end

        S_MUL: begin
          // high part starts below max_value since the quotient is below 2^NW
          rem   <= product[PW-1:NW];
          quo   <= product[NW-1:0];
          step  <= '0;
          state <= S_DIV;
        end

        S_DIV: begin
          rem  <= trial_ge ? VW'(trial - {1'b0, mv_eff}) : trial[VW-1:0];
          quo  <= {quo[NW-2:0], trial_ge};
          step <= step + SW'(1);
          if (step == SW'(NW - 1)) begin
            state <= S_PICK;
          end
        end

        S_PICK: begin
          addr      <= AW'(pick);
          res_index <= ubh_pkg::INDEX_W'(pick);
          state     <= S_READ;
        end

        S_READ: begin
          // RAM read in flight
          state <= S_RMW;
        end

        S_RMW: begin
          if (op == ubh_pkg::OP_READ) begin
            res_status <= ubh_pkg::ST_READ;
            res_count  <= rd_ok ? ram_rdata : '0;
          end else begin
            res_status <= ubh_pkg::ST_COUNTED;
            res_count  <= cell_inc;
            if (in_range_count != '1) begin
              in_range_count <= in_range_count + COUNT_BITS'(1);
            end
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            cell_index      <= res_index;
            cell_count      <= ubh_pkg::TOTAL_W'(res_count);
            in_range_total  <= ubh_pkg::TOTAL_W'(in_range_count);
            overflow_total  <= ubh_pkg::TOTAL_W'(overflow_count);
            underflow_total <= ubh_pkg::TOTAL_W'(underflow_count);
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted word always moves the sequencer out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accepting a word");

  // Bin RAM is written only by the clear sweep or by an add.
  a_ram_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CLEAR) || ((state == S_RMW) && (op == ubh_pkg::OP_ADD))))
    else $error("unexpected bin RAM write");

  // An incremented cell lies inside the configured cell range.
  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RMW) && (op == ubh_pkg::OP_ADD)) |-> (32'(addr) < 32'(n_eff)))
    else $error("increment outside the configured cells");

  // A new result word only appears out of the done state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result word raised outside the done state");

endmodule

// ----- sim/uniform_bin_histogram_test.sv -----
module uniform_bin_histogram_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CELLS           = ubh_pkg::DEF_MAX_CELLS;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned WORDS_PER_PHASE = 80;
  // Leave a wide margin after the last result before touching registers.
  localparam int unsigned SETTLE_CYCLES   = 40;
  // Set far above the slowest legal run (reset sweep and 664 words).
  localparam int unsigned CYCLE_LIMIT     = 200000;

  // One input word as the driver holds it.
  typedef struct packed {
    logic                         op;
    logic [ubh_pkg::SAMPLE_W-1:0] value;
    logic [ubh_pkg::INDEX_W-1:0]  slot;
  } word_t;

  // One result word, field for field as the block presents it.
  typedef struct packed {
    ubh_pkg::status_t            status;
    logic [ubh_pkg::INDEX_W-1:0] idx;
    logic [ubh_pkg::TOTAL_W-1:0] count;
    logic [ubh_pkg::TOTAL_W-1:0] in_range;
    logic [ubh_pkg::TOTAL_W-1:0] overflow;
    logic [ubh_pkg::TOTAL_W-1:0] underflow;
  } reply_t;

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                cfg_write = 1'b0;
  logic                                cfg_index = ubh_pkg::REG_NUM_CELLS;
  logic [ubh_pkg::MAX_VALUE_W-1:0]     cfg_data  = '0;
  logic                                in_valid  = 1'b0;
  logic                                in_ready;
  logic                                opcode    = ubh_pkg::OP_ADD;
  logic signed [ubh_pkg::SAMPLE_W-1:0] sample    = '0;
  logic [ubh_pkg::INDEX_W-1:0]         read_cell = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  ubh_pkg::status_t                    status;
  logic [ubh_pkg::INDEX_W-1:0]         cell_index;
  logic [ubh_pkg::TOTAL_W-1:0]         cell_count;
  logic [ubh_pkg::TOTAL_W-1:0]         in_range_total;
  logic [ubh_pkg::TOTAL_W-1:0]         overflow_total;
  logic [ubh_pkg::TOTAL_W-1:0]         underflow_total;

  uniform_bin_histogram u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .sample          (sample),
    .read_cell       (read_cell),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .cell_index      (cell_index),
    .cell_count      (cell_count),
    .in_range_total  (in_range_total),
    .overflow_total  (overflow_total),
    .underflow_total (underflow_total)
  );

  always #1 clk = ~clk;

  // Shadow of the histogram: bin store, running totals and the two registers.
  logic [ubh_pkg::TOTAL_W-1:0]     bin_tally [CELLS];
  logic [ubh_pkg::TOTAL_W-1:0]     in_range_tally  = '0;
  logic [ubh_pkg::TOTAL_W-1:0]     overflow_tally  = '0;
  logic [ubh_pkg::TOTAL_W-1:0]     underflow_tally = '0;
  logic [ubh_pkg::NUM_CELLS_W-1:0] cells_reg = ubh_pkg::NUM_CELLS_RST;
  logic [ubh_pkg::MAX_VALUE_W-1:0] max_reg   = ubh_pkg::MAX_VALUE_RST;
  logic [ubh_pkg::INDEX_W-1:0]     last_bin  = '0;

  word_t  sample_words[$];  // words waiting for the driver
  reply_t replies_due[$];   // shadow results, oldest first
  word_t  held_word;
  reply_t shadow_reply;
  reply_t oldest_reply;

  int unsigned in_gap, out_hold;
  bit          in_calm, out_calm;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned settings_run;
  int unsigned status_hits [4];

  // Counters stick at all ones.
  function automatic logic [ubh_pkg::TOTAL_W-1:0] bump(input logic [ubh_pkg::TOTAL_W-1:0] c);
    return (&c) ? c : c + ubh_pkg::TOTAL_W'(1);
  endfunction

  // Zero cells means one, anything past the store size means the store size.
  function automatic logic [63:0] live_cells();
    if (cells_reg == 0) return 64'd1;
    if (cells_reg > CELLS) return 64'(CELLS);
    return 64'(cells_reg);
  endfunction

  function automatic logic [63:0] live_max();
    return (max_reg == 0) ? 64'd1 : 64'(max_reg);
  endfunction

  // Apply one accepted word to the shadow histogram and return the result it should produce.
  function automatic reply_t histo_update(input word_t w);
    reply_t      r;
    logic [63:0] raw, top, n, k;
    r   = '0;
    raw = 64'(w.value);
    top = live_max();
    n   = live_cells();
    if (w.op == ubh_pkg::OP_READ) begin
      // Reads echo the index and return whatever is stored, even above num_cells.
      r.status = ubh_pkg::ST_READ;
      r.idx    = w.slot;
      r.count  = bin_tally[w.slot];
    end else if (w.value[ubh_pkg::SAMPLE_W-1]) begin
      r.status        = ubh_pkg::ST_UNDERFLOW;
      underflow_tally = bump(underflow_tally);
    end else if (raw > top) begin
      r.status       = ubh_pkg::ST_OVERFLOW;
      overflow_tally = bump(overflow_tally);
    end else begin
      // Exact floor division; a sample equal to the maximum lands in the last bin.
      k = (raw == top) ? n - 1 : (raw * n) / top;
      if (k >= n) k = n - 1;
      bin_tally[k[ubh_pkg::INDEX_W-1:0]] = bump(bin_tally[k[ubh_pkg::INDEX_W-1:0]]);
      in_range_tally                     = bump(in_range_tally);
      last_bin = k[ubh_pkg::INDEX_W-1:0];
      r.status = ubh_pkg::ST_COUNTED;
      r.idx    = k[ubh_pkg::INDEX_W-1:0];
      r.count  = bin_tally[k[ubh_pkg::INDEX_W-1:0]];
    end
    r.in_range  = in_range_tally;
    r.overflow  = overflow_tally;
    r.underflow = underflow_tally;
    return r;
  endfunction

  function automatic int unsigned gap_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Mostly in-range samples so bins fill up, with boundaries, overflow, underflow and reads.
  function automatic word_t random_word();
    word_t       w;
    logic [63:0] top, n, k, s;
    int unsigned pick;
    w.op    = ubh_pkg::OP_ADD;
    w.value = $urandom;
    w.slot  = ubh_pkg::INDEX_W'($urandom);
    top  = live_max();
    n    = live_cells();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      w.op = ubh_pkg::OP_READ;
      if (pick < 5) w.slot = last_bin;
      else if (pick < 8) w.slot = ubh_pkg::INDEX_W'($urandom_range(32'(n - 1), CELLS - 1));
    end else if (pick < 55) begin
      w.value = $urandom_range(0, 32'(top));
    end else if (pick < 70) begin
      // First sample of a random bin and the one just below it, or zero, the maximum and its neighbours.
      k = 64'($urandom_range(0, 32'(n - 1)));
      s = (k * top + n - 1) / n;
      case ($urandom_range(0, 5))
        0:       w.value = '0;
        1:       w.value = 32'(top);
        2:       w.value = 32'(top - 1);
        3:       w.value = 32'(top + 1);
        4:       w.value = 32'(s);
        default: w.value = (s == 0) ? '0 : 32'(s - 1);
      endcase
    end else if (pick < 80) begin
      if (top < 64'h7FFF_FFFF) w.value = $urandom_range(32'(top + 1), 32'h7FFF_FFFF);
      else w.value = 32'(top);
    end else if (pick < 90) begin
      w.value = {1'b1, 31'($urandom)};
    end
    return w;
  endfunction

  task automatic push_add(input logic [ubh_pkg::SAMPLE_W-1:0] v);
    sample_words.push_back('{op: ubh_pkg::OP_ADD, value: v,
                             slot: ubh_pkg::INDEX_W'($urandom)});
  endtask

  task automatic push_read(input logic [ubh_pkg::INDEX_W-1:0] c);
    sample_words.push_back('{op: ubh_pkg::OP_READ, value: ubh_pkg::SAMPLE_W'($urandom),
                             slot: c});
  endtask

  // Register writes happen only while idle, so the shadow copy can follow at once.
  task automatic write_reg(input logic idx, input logic [ubh_pkg::MAX_VALUE_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == ubh_pkg::REG_NUM_CELLS) cells_reg = data[ubh_pkg::NUM_CELLS_W-1:0];
    else max_reg = data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(input logic [ubh_pkg::NUM_CELLS_W-1:0] n,
                            input logic [ubh_pkg::MAX_VALUE_W-1:0] m);
    write_reg(ubh_pkg::REG_NUM_CELLS, ubh_pkg::MAX_VALUE_W'(n));
    write_reg(ubh_pkg::REG_MAX_VALUE, m);
    settings_run++;
    @(negedge clk);
  endtask

  // Sample at the falling edge, after the driver and the block have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_words.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Driver: present one word at a time, hold it until taken, then idle a random number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        shadow_reply = histo_update(held_word);
        replies_due.push_back(shadow_reply);
        status_hits[shadow_reply.status]++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_words.size() != 0) begin
          held_word = sample_words.pop_front();
          opcode    <= held_word.op;
          sample    <= held_word.value;
          read_cell <= held_word.slot;
          in_valid  <= 1'b1;
          // Flip between bursty and back-to-back stretches now and then.
          if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
          in_gap = gap_draw(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take result words with random stalls and compare against the oldest shadow result.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word, expected none, got status %0d cell %0d count %h",
                   $time, status, cell_index, cell_count);
        end else begin
          oldest_reply = replies_due.pop_front();
          check_field("status", 32'(oldest_reply.status), 32'(status));
          check_field("cell_index", 32'(oldest_reply.idx), 32'(cell_index));
          check_field("cell_count", oldest_reply.count, cell_count);
          check_field("in_range_total", oldest_reply.in_range, in_range_total);
          check_field("overflow_total", oldest_reply.overflow, overflow_total);
          check_field("underflow_total", oldest_reply.underflow, underflow_total);
        end
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        out_hold = gap_draw(out_calm);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a lost or stuck word ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, replies_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    foreach (bin_tally[i]) bin_tally[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset defaults: 256 bins over 0..65536.
    push_add(32'd0);
    push_add(32'd65536);
    push_add(32'd65535);
    push_add(32'd256);
    push_add(32'd255);
    push_add(32'd65537);
    push_add(32'h7FFF_FFFF);
    push_add(32'hFFFF_FFFF);
    push_add(32'h8000_0000);
    push_read(8'd0);
    push_read(8'd255);
    push_read(8'd1);
    push_read(8'd128);
    wait_idle();

    // Zero registers act as one: a single bin covering 0..1.
    set_config('0, '0);
    push_add(32'd0);
    push_add(32'd1);
    push_add(32'd2);
    push_read(8'd0);
    push_read(8'd255);
    wait_idle();

    // Oversized bin count clamps to the store size; widest range.
    set_config('1, '1);
    push_add(32'h7FFF_FFFF);
    push_add(32'h7FFF_FFFE);
    push_add(32'h0080_0000);
    push_add(32'h007F_FFFF);
    push_read(8'd255);
    push_read(8'd1);
    wait_idle();

    // Random phases: fixed extremes first, then fully random settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(9'd256, 31'd65536);
        1: set_config(9'd1, 31'd1);
        2: set_config(9'd0, 31'h7FFF_FFFF);
        3: set_config(9'd511, 31'd1000);
        4: set_config(9'd300, 31'd255);
        5: set_config(9'd17, 31'd100000);
        default: set_config(ubh_pkg::NUM_CELLS_W'($urandom_range(0, 511)),
                            $urandom_range(0, 1)
                              ? ubh_pkg::MAX_VALUE_W'($urandom_range(0, 5000))
                              : ubh_pkg::MAX_VALUE_W'($urandom));
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) sample_words.push_back(random_word());
      wait_idle();
    end

    $display("covered %0d words over %0d register settings",
             status_hits[ubh_pkg::ST_COUNTED] + status_hits[ubh_pkg::ST_OVERFLOW] +
             status_hits[ubh_pkg::ST_UNDERFLOW] + status_hits[ubh_pkg::ST_READ],
             settings_run + 1);
    $display("binned %0d, overflow %0d, underflow %0d, reads %0d, mismatches %0d",
             status_hits[ubh_pkg::ST_COUNTED], status_hits[ubh_pkg::ST_OVERFLOW],
             status_hits[ubh_pkg::ST_UNDERFLOW], status_hits[ubh_pkg::ST_READ], mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ubh_pkg.sv
sv/ubh_ram.sv
sv/uniform_bin_histogram.sv
sim/uniform_bin_histogram_test.sv
